// File: sv/wto_pkg.sv
// Shared constants and field layout for the wavetable oscillator.
package wto_pkg;

   localparam int TABLE_DEPTH = 4096;
   localparam int PHASE_BITS  = 32;
   localparam int SAMPLE_BITS = 16;

   localparam int ADDR_W  = $clog2(TABLE_DEPTH);
   localparam int LEN_W   = ADDR_W + 1;
   localparam int FRAC_W  = 16;
   localparam int POS_W   = PHASE_BITS + LEN_W;
   localparam int OPC_W   = 2;
   localparam int REQ_W   = 32;
   localparam int RSP_W   = 16;
   localparam int CSR_W   = 32;
   localparam int CSR_IDX_W = 2;

   localparam logic [OPC_W-1:0] OPC_SAMPLE = 2'd0;
   localparam logic [OPC_W-1:0] OPC_WRITE  = 2'd1;
   localparam logic [OPC_W-1:0] OPC_CLEAR  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_INC = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_LEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINEAR    = 2'd2;

   localparam logic [PHASE_BITS-1:0] PHASE_HALF = PHASE_BITS'(1) << (PHASE_BITS - 1);
   localparam logic [LEN_W-1:0]      LEN_MAX    = LEN_W'(TABLE_DEPTH);
   localparam logic [LEN_W-1:0]      LEN_RESET  = LEN_W'(TABLE_DEPTH);
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_BIAS = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

endpackage

// File: sv/wavetable_oscillator.sv
// Wavetable oscillator: phase accumulator, table memory and linear blend.
// Words are accepted only while idle; a sample word then passes the add, multiply,
// table read and blend steps, and no new word is taken until its result is loaded.
// Table write and clear-phase words are taken while idle and do not leave it.
// The table memory is single-write, dual-read, with registered read data.
// Reset (synchronous) zeroes the phase and restores the registers; table is not cleared.
module wavetable_oscillator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // opcode[1:0], table_address[13:2], entry_value[29:14], zero pad
   input  logic [wto_pkg::REQ_W-1:0]     req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // sample_out[15:0]
   output logic [wto_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                          csr_wr_en,
   input  logic [wto_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wto_pkg::CSR_W-1:0]     csr_wr_data
);
   import wto_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_MUL   = 2'd1;
   localparam logic [1:0] S_READ  = 2'd2;
   localparam logic [1:0] S_BLEND = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [PHASE_BITS-1:0]  inc_ff;
   logic [LEN_W-1:0]       len_ff;
   logic                   linear_ff;
   logic [PHASE_BITS-1:0]  phase_ff, phase_in;
   logic [POS_W-1:0]       pos_ff;
   logic [SAMPLE_BITS-1:0] rd_a_ff, rd_b_ff;
   logic [FRAC_W-1:0]      frac_ff;
   logic                   rsp_valid_ff;
   logic [SAMPLE_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [SAMPLE_BITS-1:0] mem [TABLE_DEPTH];

   logic [OPC_W-1:0]       req_opcode;
   logic [ADDR_W-1:0]      req_addr;
   logic [SAMPLE_BITS-1:0] req_value;
   logic                   req_fire;
   logic [PHASE_BITS-1:0]  inc_clamped;
   logic [LEN_W-1:0]       len_eff;
   logic [LEN_W-1:0]       idx_raw, idx, idx_inc, idx_nx;
   logic                   out_load;
   logic [SAMPLE_BITS-1:0] a_bias, b_bias;
   logic [FRAC_W:0]        w_a;
   logic [SAMPLE_BITS+FRAC_W+1:0] blend_sum;

   assign req_opcode = req_tdata[OPC_W-1:0];
   assign req_addr   = req_tdata[OPC_W +: ADDR_W];
   assign req_value  = req_tdata[OPC_W + ADDR_W +: SAMPLE_BITS];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign inc_clamped = (inc_ff > PHASE_HALF) ? PHASE_HALF : inc_ff;
   assign len_eff = (len_ff == '0) ? LEN_W'(1) : ((len_ff > LEN_MAX) ? LEN_MAX : len_ff);

   assign idx_raw = pos_ff[POS_W-1 -: LEN_W];
   assign idx     = (idx_raw >= len_eff) ? (len_eff - LEN_W'(1)) : idx_raw;
   assign idx_inc = idx + LEN_W'(1);
   assign idx_nx  = (idx_inc == len_eff) ? '0 : idx_inc;

   assign a_bias    = rd_a_ff ^ SAMPLE_BIAS;
   assign b_bias    = rd_b_ff ^ SAMPLE_BIAS;
   assign w_a       = (FRAC_W+1)'(1) << FRAC_W;
   assign blend_sum = ($bits(blend_sum))'(a_bias)
                      * ($bits(blend_sum))'(w_a - (FRAC_W+1)'(frac_ff))
                    + ($bits(blend_sum))'(b_bias) * ($bits(blend_sum))'(frac_ff)
                    + (($bits(blend_sum))'(1'b1) << (FRAC_W - 1));

   assign out_load = (state_ff == S_BLEND) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_data_in = rd_a_ff;
      if (linear_ff) begin
         rsp_data_in = blend_sum[FRAC_W +: SAMPLE_BITS] ^ SAMPLE_BIAS;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      if (req_fire && req_opcode == OPC_SAMPLE) begin
         phase_in = phase_ff + inc_clamped;
      end else if (req_fire && req_opcode == OPC_CLEAR) begin
         phase_in = '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && req_opcode == OPC_SAMPLE) state_in = S_MUL;
         end
         S_MUL:   state_in = S_READ;
         S_READ:  state_in = S_BLEND;
         S_BLEND: begin
            if (out_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= '0;
         inc_ff       <= '0;
         len_ff       <= LEN_RESET;
         linear_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PHASE_INC: inc_ff    <= csr_wr_data[PHASE_BITS-1:0];
               CSR_TABLE_LEN: len_ff    <= csr_wr_data[LEN_W-1:0];
               CSR_LINEAR:    linear_ff <= csr_wr_data[0];
               default: ;
            endcase
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_MUL) begin
         pos_ff <= POS_W'(phase_ff) * POS_W'(len_eff);
      end
      if (state_ff == S_READ) begin
         frac_ff <= pos_ff[PHASE_BITS-1 -: FRAC_W];
      end
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // table memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (req_fire && req_opcode == OPC_WRITE) begin
         mem[req_addr] <= req_value;
      end
      if (state_ff == S_READ) begin
         rd_a_ff <= mem[idx[ADDR_W-1:0]];
         rd_b_ff <= mem[idx_nx[ADDR_W-1:0]];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_clear_zeroes_phase: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_opcode == OPC_CLEAR |=> phase_ff == '0)
      else $error("phase not cleared");

   a_write_keeps_phase: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_opcode == OPC_WRITE |=> $stable(phase_ff))
      else $error("table write moved phase");

   a_sample_starts_mul: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_opcode == OPC_SAMPLE |=> state_ff == S_MUL)
      else $error("sample word did not start");

   a_result_from_blend: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_BLEND)
      else $error("result word without blend stage");

   a_sample_phase_step: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_opcode == OPC_SAMPLE |=>
         phase_ff == $past(phase_ff) + $past(inc_clamped))
      else $error("phase step wrong");

endmodule

// File: test/wto_checker.sv
// Checker for the wavetable oscillator: predicts each sample word and compares results.
`timescale 1ns / 100ps
module wto_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   // opcode[1:0], table_address[13:2], entry_value[29:14], zero pad
   input  logic [wto_pkg::REQ_W-1:0]     req_tdata,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // sample_out[15:0]
   input  logic [wto_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                          csr_wr_en,
   input  logic [wto_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wto_pkg::CSR_W-1:0]     csr_wr_data,
   output int                            pending,
   output int                            mismatches
);
   import wto_pkg::*;

   logic [PHASE_BITS-1:0]  phase_inc;
   logic [LEN_W-1:0]       table_len;
   logic                   linear;
   logic [PHASE_BITS-1:0]  phase;
   logic [SAMPLE_BITS-1:0] wave_mem [TABLE_DEPTH];
   logic [SAMPLE_BITS-1:0] expected_samples [$];
   int                     fail_count = 0;

   // advance the phase and look up / blend the table
   function automatic logic [SAMPLE_BITS-1:0] predict_sample();
      logic [PHASE_BITS-1:0] step;
      logic [LEN_W-1:0]      span;
      logic [POS_W-1:0]      pos;
      logic [LEN_W-1:0]      idx;
      logic [LEN_W-1:0]      nxt;
      logic [FRAC_W-1:0]     frac;
      logic [63:0]           a;
      logic [63:0]           b;
      logic [63:0]           acc;
      step = (phase_inc > PHASE_HALF) ? PHASE_HALF : phase_inc;
      if (table_len == '0)
         span = LEN_W'(1);
      else if (table_len > LEN_MAX)
         span = LEN_MAX;
      else
         span = table_len;
      phase = phase + step;
      pos = POS_W'(phase) * POS_W'(span);
      idx = pos[POS_W-1:PHASE_BITS];
      if (idx >= span)
         idx = span - 1'b1;
      frac = pos[PHASE_BITS-1 -: FRAC_W];
      if (!linear)
         return wave_mem[idx[ADDR_W-1:0]];
      nxt = (idx + 1 == span) ? '0 : idx + 1'b1;
      a = 64'(wave_mem[idx[ADDR_W-1:0]] ^ SAMPLE_BIAS);
      b = 64'(wave_mem[nxt[ADDR_W-1:0]] ^ SAMPLE_BIAS);
      acc = a * (64'd65536 - 64'(frac)) + b * 64'(frac) + 64'd32768;
      return acc[31:16] ^ SAMPLE_BIAS;
   endfunction

   always @(posedge clock) begin : monitor
      logic [SAMPLE_BITS-1:0] want;
      if (reset) begin
         phase_inc = '0;
         table_len = LEN_RESET;
         linear = 1'b1;
         phase = '0;
         expected_samples.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PHASE_INC: phase_inc = csr_wr_data[PHASE_BITS-1:0];
               CSR_TABLE_LEN: table_len = csr_wr_data[LEN_W-1:0];
               CSR_LINEAR:    linear = csr_wr_data[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            case (req_tdata[OPC_W-1:0])
               OPC_SAMPLE: expected_samples.push_back(predict_sample());
               OPC_WRITE:  wave_mem[req_tdata[OPC_W +: ADDR_W]] =
                              req_tdata[OPC_W+ADDR_W +: SAMPLE_BITS];
               OPC_CLEAR:  phase = '0;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected sample word %h", $time, rsp_tdata);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_tdata[SAMPLE_BITS-1:0] !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: sample_out expected %h, got %h", $time, want, rsp_tdata);
               end
            end
         end
      end
      pending <= expected_samples.size();
      mismatches <= fail_count;
   end

endmodule

// File: test/tb.sv
// Testbench top for the wavetable oscillator: stimulus, handshake pacing and verdict.
`timescale 1ns / 100ps
module tb;
   import wto_pkg::*;

   localparam logic [OPC_W-1:0]     OPC_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int IDLE_LIMIT   = 5000;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 850;
   localparam int LEN_ALL_ONES = (1 << LEN_W) - 1;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wr_data = '0;

   int   pending;
   int   mismatches;
   bit   loaded [TABLE_DEPTH];
   bit   burst = 1'b0;
   logic hold_rsp = 1'b0;
   int   quiet_cycles = 0;
   int   random_items = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   wavetable_oscillator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   wto_checker chk (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .pending     (pending),
      .mismatches  (mismatches)
   );

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int span_of(int len);
      if (len == 0)
         return 1;
      if (len > TABLE_DEPTH)
         return TABLE_DEPTH;
      return len;
   endfunction

   function automatic logic [31:0] pick_inc();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return PHASE_HALF;
      if (r == 1)
         return 32'hFFFF_FFFF;
      if (r == 2)
         return 32'h0;
      if (r < 6)
         return $urandom_range(1, 32'h00FF_FFFF);
      return $urandom;
   endfunction

   function automatic int pick_len();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 0;
      if (r == 1)
         return $urandom_range(33, 300);
      return $urandom_range(1, 32);
   endfunction

   task automatic send(input logic [OPC_W-1:0] opc, input logic [ADDR_W-1:0] addr,
                       input logic [SAMPLE_BITS-1:0] value);
      int gap;
      gap = burst ? 0 : idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'({value, addr, opc});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (opc == OPC_WRITE)
         loaded[addr] = 1'b1;
   endtask

   task automatic request_sample();
      send(OPC_SAMPLE, ADDR_W'($urandom), SAMPLE_BITS'($urandom));
   endtask

   // drain every expected sample, then let trailing write/clear words retire
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] inc, input int len, input bit lin);
      settle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_PHASE_INC;
      csr_wr_data <= inc;
      @(posedge clock);
      csr_index <= CSR_TABLE_LEN;
      csr_wr_data <= (CSR_W'($urandom) << LEN_W) | CSR_W'(len);
      @(posedge clock);
      csr_index <= CSR_LINEAR;
      csr_wr_data <= (CSR_W'($urandom) << 1) | CSR_W'(lin);
      @(posedge clock);
      if ($urandom_range(0, 3) == 0) begin
         csr_index <= CSR_UNUSED;
         csr_wr_data <= $urandom;
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_phase(input logic [31:0] inc, input int len, input bit lin,
                               input int count);
      int span;
      int r;
      logic [ADDR_W-1:0] addr;
      logic [SAMPLE_BITS-1:0] value;
      configure(inc, len, lin);
      span = span_of(len);
      burst = ($urandom_range(0, 3) == 0);
      // every entry the oscillator can reach must hold a word first
      for (int a = 0; a < span; a++)
         if (!loaded[a])
            send(OPC_WRITE, ADDR_W'(a), SAMPLE_BITS'($urandom));
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 68) begin
            request_sample();
         end else if (r < 86) begin
            addr = ($urandom_range(0, 3) == 0) ? ADDR_W'($urandom_range(0, TABLE_DEPTH - 1))
                                               : ADDR_W'($urandom_range(0, span - 1));
            case ($urandom_range(0, 9))
               0: value = 16'h8000;
               1: value = 16'h7FFF;
               default: value = SAMPLE_BITS'($urandom);
            endcase
            send(OPC_WRITE, addr, value);
         end else if (r < 94) begin
            send(OPC_CLEAR, ADDR_W'($urandom), SAMPLE_BITS'($urandom));
         end else begin
            send(OPC_UNUSED, ADDR_W'($urandom), SAMPLE_BITS'($urandom));
         end
         if (r < 94)
            random_items++;
      end
      burst = 1'b0;
   endtask

   // long tables: start from phase zero and load only the entries the walk reaches
   task automatic long_table_phase(input logic [31:0] inc, input int len, input bit lin,
                                   input int count);
      int span;
      int idx;
      logic [PHASE_BITS-1:0] step;
      logic [PHASE_BITS-1:0] ph;
      logic [POS_W-1:0]      pos;
      configure(inc, len, lin);
      span = span_of(len);
      step = (inc > PHASE_HALF) ? PHASE_HALF : inc;
      ph = '0;
      send(OPC_CLEAR, ADDR_W'(0), SAMPLE_BITS'(0));
      for (int n = 0; n < count; n++) begin
         ph = ph + step;
         pos = POS_W'(ph) * POS_W'(span);
         idx = int'(pos[POS_W-1:PHASE_BITS]);
         if (idx >= span)
            idx = span - 1;
         if (!loaded[idx])
            send(OPC_WRITE, ADDR_W'(idx), SAMPLE_BITS'($urandom));
         if (!loaded[(idx + 1) % span])
            send(OPC_WRITE, ADDR_W'((idx + 1) % span), SAMPLE_BITS'($urandom));
      end
      repeat (count) request_sample();
   endtask

   // result side: random stalls, ready stretches, one long hold on request
   initial begin : sink
      int stall_left;
      int ready_left;
      bit hold_taken;
      stall_left = 0;
      ready_left = 0;
      hold_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp && !hold_taken) begin
            hold_taken = 1'b1;
            stall_left = HOLD_CYCLES;
            ready_left = 0;
         end
         if (stall_left == 0 && ready_left == 0) begin
            stall_left = idle_gap();
            ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 8);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            ready_left--;
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // quarter-cycle steps land exactly on entries
      configure(32'h4000_0000, 4, 1'b1);
      send(OPC_WRITE, 12'd0, 16'h8000);
      send(OPC_WRITE, 12'd1, 16'h7FFF);
      send(OPC_WRITE, 12'd2, 16'h0000);
      send(OPC_WRITE, 12'd3, 16'hFFFF);
      send(OPC_WRITE, 12'hFFF, 16'h7FFF);
      repeat (4) request_sample();
      send(OPC_CLEAR, 12'hFFF, 16'hFFFF);
      send(OPC_UNUSED, 12'h000, 16'h0000);
      repeat (2) request_sample();
      // fractional positions, blend across the wrap
      configure(32'h3000_0000, 4, 1'b1);
      repeat (4) request_sample();
      // step above one half is clamped, table entry without blending
      configure(32'hFFFF_FFFF, 4, 1'b0);
      repeat (3) request_sample();
      // zero length behaves as one entry
      configure(32'h1234_5678, 0, 1'b1);
      repeat (2) request_sample();

      // result side holds off while samples keep coming
      settle();
      hold_rsp <= 1'b1;
      burst = 1'b1;
      repeat (40) request_sample();
      burst = 1'b0;

      while (random_items < RANDOM_ITEMS)
         random_phase(pick_inc(), pick_len(), 1'($urandom), $urandom_range(20, 80));
      long_table_phase(pick_inc(), TABLE_DEPTH, 1'b1, 40);
      long_table_phase(pick_inc(), LEN_ALL_ONES, 1'b0, 30);
      long_table_phase(PHASE_HALF, LEN_ALL_ONES, 1'b1, 30);

      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// File: wavetable_oscillator.f
sv/wto_pkg.sv
sv/wavetable_oscillator.sv
test/wto_checker.sv
test/tb.sv
